// ===== src/rscs_pkg.sv =====
// Shared types and constants for the radial simplify and corner-cut smoother.
// Used by the interfaces, the controller, the datapath and the top level.
package rscs_pkg;

  localparam int MAX_PASSES  = 3;
  localparam int COORD_BITS  = 24;
  localparam int FRAC_BITS   = 8;
  localparam int RADIUS_BITS = 12;
  localparam int PASS_BITS   = 2;
  localparam int K_BITS      = $clog2(MAX_PASSES + 1);
  localparam int STACK_DEPTH = 2 * MAX_PASSES + 1;
  localparam int SP_BITS     = $clog2(STACK_DEPTH + 1);
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * DIFF_BITS;
  localparam int SUM_BITS    = SQ_BITS + 1;
  localparam int RQ_BITS     = RADIUS_BITS + FRAC_BITS;
  localparam int THR_BITS    = 2 * RQ_BITS;
  localparam int CFG_IDX_BITS = 1;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH_PASSES = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DROP_RADIUS   = 1'b1;

  localparam logic [PASS_BITS-1:0]   PASSES_RESET = 2'd2;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 12'd35;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // One pending call into the smoothing stages.
  typedef struct packed {
    logic [K_BITS-1:0] k;
    pt_t               pt;
    logic              last;
  } feed_t;

  typedef enum logic [2:0] {
    SRC_H0,
    SRC_H1,
    SRC_H2,
    SRC_P,
    SRC_PEND
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_HEAD_PUSH,
    ST_HEAD_RUN,
    ST_SEL,
    ST_DIST1,
    ST_DIST2,
    ST_DIST3,
    ST_PK_FEED,
    ST_PK_RUN,
    ST_PK_SET,
    ST_NEXT,
    ST_FIN,
    ST_FIN_RUN,
    ST_END
  } state_t;

  typedef struct packed {
    logic head_write;
    logic push;
    logic push_direct;
    logic push_last;
    src_t src;
    logic pk_set;
    logic path_end;
  } cmd_t;

  typedef struct packed {
    logic       stk_empty;
    logic       far;
    logic [1:0] hc;
    logic       pending_valid;
    logic       last;
    logic       p_eq_kept;
    logic       radius_zero;
  } stat_t;

endpackage

// ===== src/rscs_if.sv =====
// Handshake channel interfaces: input points, output points and register writes.
// Depends on rscs_pkg for the coordinate and register widths.
interface rscs_point_if import rscs_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;
  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

interface rscs_smooth_if import rscs_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t smooth_x;
  coord_t smooth_y;
  logic   last_out;
  modport source (output valid, output smooth_x, output smooth_y, output last_out,
                  input ready);
  modport sink (input valid, input smooth_x, input smooth_y, input last_out,
                output ready);
endinterface

interface rscs_cfg_if import rscs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [RADIUS_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/rscs_ctrl.sv =====
// Controller state machine: sequences head handling, distance tests, kept-point
// updates and path end. Depends on rscs_pkg; drives the datapath by cmd_t.
module rscs_ctrl import rscs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  stat_t  stat,
  output logic   in_ready,
  output cmd_t   cmd
);

  state_t     state, state_next;
  logic [1:0] ph;
  logic [1:0] j;
  src_t       ph_src;
  src_t       j_src;
  logic       keep_it;

  // Point under test for the current phase.
  always_comb begin
    case (ph)
      2'd0:    ph_src = SRC_H0;
      2'd1:    ph_src = SRC_H1;
      2'd2:    ph_src = SRC_H2;
      default: ph_src = SRC_P;
    endcase
    case (j)
      2'd0:    j_src = SRC_H0;
      2'd1:    j_src = SRC_H1;
      default: j_src = SRC_H2;
    endcase
  end

  assign keep_it = stat.radius_zero || stat.far;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (accept) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (stat.hc != 2'd3) begin
          state_next = stat.last ? ST_HEAD_PUSH : ST_IDLE;
        end else begin
          state_next = ST_SEL;
        end
      end
      ST_HEAD_PUSH: state_next = ST_HEAD_RUN;
      ST_HEAD_RUN: begin
        if (stat.stk_empty) state_next = (j == stat.hc) ? ST_END : ST_HEAD_PUSH;
      end
      ST_SEL: begin
        if (ph == 2'd0) begin
          state_next = ST_PK_FEED;
        end else if (ph == 2'd3 && stat.last) begin
          state_next = (stat.radius_zero || !stat.p_eq_kept) ? ST_PK_FEED : ST_FIN;
        end else begin
          state_next = ST_DIST1;
        end
      end
      ST_DIST1:     state_next = ST_DIST2;
      ST_DIST2:     state_next = ST_DIST3;
      ST_DIST3:     state_next = keep_it ? ST_PK_FEED : ST_NEXT;
      ST_PK_FEED:   state_next = stat.pending_valid ? ST_PK_RUN : ST_PK_SET;
      ST_PK_RUN:    if (stat.stk_empty) state_next = ST_PK_SET;
      ST_PK_SET:    state_next = ST_NEXT;
      ST_NEXT: begin
        if (ph != 2'd3) state_next = ST_SEL;
        else            state_next = stat.last ? ST_FIN : ST_IDLE;
      end
      ST_FIN:       state_next = stat.pending_valid ? ST_FIN_RUN : ST_END;
      ST_FIN_RUN:   if (stat.stk_empty) state_next = ST_END;
      ST_END:       state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    cmd.src = ph_src;
    in_ready = 1'b0;
    case (state)
      ST_IDLE:     in_ready = 1'b1;
      ST_DISPATCH: cmd.head_write = (stat.hc != 2'd3);
      ST_HEAD_PUSH: begin
        cmd.push        = 1'b1;
        cmd.src         = j_src;
        cmd.push_direct = (stat.hc != 2'd3);
        cmd.push_last   = (j == stat.hc - 2'd1);
      end
      ST_PK_FEED: begin
        cmd.push = stat.pending_valid;
        cmd.src  = SRC_PEND;
      end
      ST_PK_SET:   cmd.pk_set = 1'b1;
      ST_FIN: begin
        cmd.push      = stat.pending_valid;
        cmd.push_last = 1'b1;
        cmd.src       = SRC_PEND;
      end
      ST_END:      cmd.path_end = 1'b1;
      default:     cmd.src = ph_src;
    endcase
  end

  // State and sequencing counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ph    <= 2'd0;
      j     <= 2'd0;
    end else begin
      state <= state_next;
      if (state == ST_DISPATCH) begin
        j  <= 2'd0;
        ph <= stat.pending_valid ? 2'd3 : 2'd0;
      end
      if (state == ST_HEAD_PUSH) j <= j + 2'd1;
      if (state == ST_NEXT && ph != 2'd3) ph <= ph + 2'd1;
    end
  end

endmodule

// ===== src/rscs_dp.sv =====
// Datapath: point storage, distance test pipeline, corner-cut stage engine with
// its call stack, configuration registers and the output register. Uses rscs_pkg.
module rscs_dp import rscs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic                    accept,
  input  coord_t                  point_x,
  input  coord_t                  point_y,
  input  logic                    last_point,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [RADIUS_BITS-1:0]  cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output coord_t                  smooth_x,
  output coord_t                  smooth_y,
  output logic                    last_out
);

  logic [PASS_BITS-1:0]   smooth_passes;
  logic [RADIUS_BITS-1:0] drop_radius;
  pt_t                    head [3];
  logic [1:0]             hc;
  pt_t                    kept, pending, p_reg;
  logic                   pending_valid, last_reg;
  pt_t                    prev [MAX_PASSES];
  logic [MAX_PASSES-1:0]  started;
  feed_t                  stack [STACK_DEPTH];
  feed_t                  stack_next [STACK_DEPTH];
  logic [SP_BITS-1:0]     sp, sp_next;
  logic [DIFF_BITS-1:0]   dx, dy;
  logic [SQ_BITS-1:0]     sx, sy;
  logic [THR_BITS-1:0]    thr;
  pt_t                    sel_pt;

  // Source point selection.
  always_comb begin
    case (cmd.src)
      SRC_H0:   sel_pt = head[0];
      SRC_H1:   sel_pt = head[1];
      SRC_H2:   sel_pt = head[2];
      SRC_P:    sel_pt = p_reg;
      SRC_PEND: sel_pt = pending;
      default:  sel_pt = p_reg;
    endcase
  end

  // Distance test: absolute differences, then squares, then compare.
  logic signed [DIFF_BITS-1:0] diff_x, diff_y;
  logic [RQ_BITS-1:0]          rq;
  assign diff_x = DIFF_BITS'(sel_pt.x) - DIFF_BITS'(kept.x);
  assign diff_y = DIFF_BITS'(sel_pt.y) - DIFF_BITS'(kept.y);
  assign rq     = {drop_radius, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    dx  <= diff_x[DIFF_BITS-1] ? DIFF_BITS'(-diff_x) : DIFF_BITS'(diff_x);
    dy  <= diff_y[DIFF_BITS-1] ? DIFF_BITS'(-diff_y) : DIFF_BITS'(diff_y);
    sx  <= SQ_BITS'(dx) * SQ_BITS'(dx);
    sy  <= SQ_BITS'(dy) * SQ_BITS'(dy);
    thr <= THR_BITS'(rq) * THR_BITS'(rq);
  end

  // Stage engine: the top of the stack is either emitted or processed.
  feed_t                top;
  logic [K_BITS-1:0]    n_pass;
  logic                 emit, can_emit, proc;
  pt_t                  a;
  logic                 a_started;
  feed_t                ch [3];
  logic [1:0]           nch;
  logic signed [COORD_BITS+2:0] ae_x, ae_y, pe_x, pe_y, tq_x, tq_y, tr_x, tr_y;

  assign top      = stack[0];
  assign n_pass   = (int'(smooth_passes) > MAX_PASSES) ? K_BITS'(MAX_PASSES)
                                                       : K_BITS'(smooth_passes);
  assign emit     = (sp != '0) && (top.k >= n_pass);
  assign can_emit = !out_valid || out_ready;
  assign proc     = (sp != '0) && (top.k < n_pass);

  always_comb begin
    a = prev[0];
    a_started = 1'b0;
    for (int i = 0; i < MAX_PASSES; i++) begin
      if (top.k == K_BITS'(i)) begin
        a = prev[i];
        a_started = started[i];
      end
    end
  end

  // Corner cuts with floor division by four.
  always_comb begin
    ae_x = (COORD_BITS+3)'(a.x);
    ae_y = (COORD_BITS+3)'(a.y);
    pe_x = (COORD_BITS+3)'(top.pt.x);
    pe_y = (COORD_BITS+3)'(top.pt.y);
    tq_x = (ae_x <<< 1) + ae_x + pe_x;
    tq_y = (ae_y <<< 1) + ae_y + pe_y;
    tr_x = (pe_x <<< 1) + pe_x + ae_x;
    tr_y = (pe_y <<< 1) + pe_y + ae_y;
  end

  // Children of the processed call, in call order.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch[i].k    = top.k + K_BITS'(1);
      ch[i].pt   = top.pt;
      ch[i].last = 1'b0;
    end
    if (a_started) begin
      ch[0].pt.x = tq_x[COORD_BITS+1:2];
      ch[0].pt.y = tq_y[COORD_BITS+1:2];
      ch[1].pt.x = tr_x[COORD_BITS+1:2];
      ch[1].pt.y = tr_y[COORD_BITS+1:2];
      nch = 2'd2;
    end else begin
      nch = 2'd1;
    end
    if (top.last) begin
      ch[nch].pt   = top.pt;
      ch[nch].last = 1'b1;
      nch = nch + 2'd1;
    end
  end

  // Stack update: push from the controller, pop on emit, replace on process.
  always_comb begin
    stack_next = stack;
    sp_next    = sp;
    if (cmd.push) begin
      stack_next[0].k    = cmd.push_direct ? K_BITS'(MAX_PASSES) : '0;
      stack_next[0].pt   = sel_pt;
      stack_next[0].last = cmd.push_last;
      sp_next = SP_BITS'(1);
    end else if (emit && can_emit) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) stack_next[i] = stack[i+1];
      sp_next = sp - SP_BITS'(1);
    end else if (proc) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        if (i < int'(nch)) begin
          stack_next[i] = ch[i];
        end else if (nch == 2'd1) begin
          stack_next[i] = stack[i];
        end else if (nch == 2'd2) begin
          if (i >= 1) stack_next[i] = stack[i-1];
        end else begin
          if (i >= 2) stack_next[i] = stack[i-2];
        end
      end
      sp_next = sp + SP_BITS'(nch) - SP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    stack <= stack_next;
    if (rst) sp <= '0;
    else     sp <= sp_next;
  end

  // Per-stage previous point and started flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= '0;
    end else if (cmd.path_end) begin
      started <= '0;
    end else if (proc && !cmd.push) begin
      for (int i = 0; i < MAX_PASSES; i++) begin
        if (top.k == K_BITS'(i)) started[i] <= !top.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && !cmd.push) begin
      for (int i = 0; i < MAX_PASSES; i++) begin
        if (top.k == K_BITS'(i)) prev[i] <= top.pt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && can_emit && !cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && can_emit && !cmd.push) begin
      smooth_x <= top.pt.x;
      smooth_y <= top.pt.y;
      last_out <= top.last;
    end
  end

  // Path state: head buffer, kept and pending points.
  always_ff @(posedge clk) begin
    if (rst) begin
      hc            <= 2'd0;
      pending_valid <= 1'b0;
      kept          <= '0;
      pending       <= '0;
    end else begin
      if (cmd.head_write) hc <= hc + 2'd1;
      if (cmd.pk_set) begin
        pending       <= sel_pt;
        kept          <= sel_pt;
        pending_valid <= 1'b1;
      end
      if (cmd.path_end) begin
        hc            <= 2'd0;
        pending_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head_write) begin
      for (int i = 0; i < 3; i++) begin
        if (hc == 2'(i)) head[i] <= p_reg;
      end
    end
    if (accept) begin
      p_reg.x  <= point_x;
      p_reg.y  <= point_y;
      last_reg <= last_point;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_passes <= PASSES_RESET;
      drop_radius   <= RADIUS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SMOOTH_PASSES) smooth_passes <= cfg_data[PASS_BITS-1:0];
      else                                drop_radius   <= cfg_data;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.stk_empty     = (sp == '0);
    stat.far           = ({1'b0, sx} + {1'b0, sy}) > SUM_BITS'(thr);
    stat.hc            = hc;
    stat.pending_valid = pending_valid;
    stat.last          = last_reg;
    stat.p_eq_kept     = (p_reg == kept);
    stat.radius_zero   = (drop_radius == '0);
  end

endmodule

// ===== src/radial_simplify_chaikin_smoother.sv =====
// Path smoother: radial distance simplification followed by corner cutting.
// Usage:
//   in_pt  - input points (point_x, point_y signed Q16.8, last_point marks path end).
//   out_pt - output points (smooth_x, smooth_y, last_out marks output path end).
//   cfg    - register writes: index 0 is smooth_passes, index 1 is drop_radius.
//   The first three points of a path are held; results appear once the path
//   is long enough or ends. A dropped interior point passes from its accept
//   to the next ready through take, dispatch, select, the three distance
//   pipeline steps (difference, square, compare) and an advance step. A kept
//   point adds a feed step, the engine run over its stage calls and output
//   points until the engine drains, and a set step; output stalls lengthen
//   it. The stage engine handles one call per cycle while the output register
//   can take its point, and its call stack sets the rate.
//   A new item is taken only after the previous one is fully handled; the
//   last output point may still sit in the output register at that time.
//   When the receiver stalls, the output register holds its item and the
//   engine waits; no item is lost. Reset (rst, synchronous) empties the path
//   state and restores smooth_passes to 2 and drop_radius to 35.
//   Configuration writes are always taken; change them only while idle.
module radial_simplify_chaikin_smoother import rscs_pkg::*; (
  input logic   clk,
  input logic   rst,
  rscs_point_if.sink    in_pt,
  rscs_smooth_if.source out_pt,
  rscs_cfg_if.sink      cfg
);

  cmd_t  cmd;
  stat_t stat;
  logic  accept;

  assign accept    = in_pt.valid && in_pt.ready;
  assign cfg.ready = 1'b1;

  rscs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .stat     (stat),
    .in_ready (in_pt.ready),
    .cmd      (cmd)
  );

  rscs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .accept     (accept),
    .point_x    (in_pt.point_x),
    .point_y    (in_pt.point_y),
    .last_point (in_pt.last_point),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (out_pt.valid),
    .out_ready  (out_pt.ready),
    .smooth_x   (out_pt.smooth_x),
    .smooth_y   (out_pt.smooth_y),
    .last_out   (out_pt.last_out)
  );

endmodule

// ===== src/rscs_checker.sv =====
// Port-level checks for the path smoother, bound to the top level.
// Depends on rscs_pkg for coordinate widths.
module rscs_checker import rscs_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t smooth_x,
  input coord_t smooth_y,
  input logic   last_out
);

  // A stalled output item stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  // Reset leaves no output item behind.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // The block works on one item at a time: no accept right after an accept.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // A stalled output item keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(smooth_x) && $stable(smooth_y) && $stable(last_out))
    else $error("output payload changed while stalled");

endmodule

bind radial_simplify_chaikin_smoother rscs_checker u_rscs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_pt.valid),
  .in_ready  (in_pt.ready),
  .out_valid (out_pt.valid),
  .out_ready (out_pt.ready),
  .smooth_x  (out_pt.smooth_x),
  .smooth_y  (out_pt.smooth_y),
  .last_out  (out_pt.last_out)
);

// ===== test/tb.sv =====
// Self-checking bench for the radial simplify and corner-cut path smoother.
// Depends on rscs_pkg, the channel interfaces and radial_simplify_chaikin_smoother.
`timescale 1ns / 1ps

module tb;
  import rscs_pkg::*;

  typedef struct {
    longint x;
    longint y;
  } xy_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } path_item_t;

  logic clk;
  logic rst;
  int   fails;

  rscs_point_if  in_if();
  rscs_smooth_if out_if();
  rscs_cfg_if    cfg_if();

  radial_simplify_chaikin_smoother dut (
    .clk    (clk),
    .rst    (rst),
    .in_pt  (in_if.sink),
    .out_pt (out_if.source),
    .cfg    (cfg_if.sink)
  );

  // Clock; the single reset pulse is driven by the main stimulus block.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow of the smoother state, kept in step with accepted items.
  xy_t         head_pts[3];
  int          head_n;
  xy_t         kept_pt;
  xy_t         pend_pt;
  bit          pend_ok;
  xy_t         cut_prev[MAX_PASSES];
  bit          cut_started[MAX_PASSES];
  int          num_passes;
  int          radius;
  path_item_t  smoothed_q[$];
  path_item_t  path_q[$];

  // Stimulus controls read by the driver and the receiver.
  bit hold_off;
  bit no_gaps;

  function automatic longint sext_coord(coord_t v);
    return longint'(v);
  endfunction

  function automatic void emit_point(xy_t p, bit last);
    path_item_t r;
    r.x = coord_t'(p.x);
    r.y = coord_t'(p.y);
    r.last = last;
    smoothed_q.push_back(r);
  endfunction

  // One corner-cut stage; stage k passes its points on to stage k+1.
  function automatic void cut_stage(int k, xy_t p, bit last);
    xy_t a;
    xy_t q;
    xy_t r;
    int n;
    n = (num_passes < MAX_PASSES) ? num_passes : MAX_PASSES;
    if (k >= n) begin
      emit_point(p, last);
      return;
    end
    if (!cut_started[k]) begin
      cut_stage(k + 1, p, 1'b0);
      cut_started[k] = 1'b1;
    end else begin
      a = cut_prev[k];
      q.x = (3 * a.x + p.x) >>> 2;
      q.y = (3 * a.y + p.y) >>> 2;
      r.x = (a.x + 3 * p.x) >>> 2;
      r.y = (a.y + 3 * p.y) >>> 2;
      cut_stage(k + 1, q, 1'b0);
      cut_stage(k + 1, r, 1'b0);
    end
    cut_prev[k] = p;
    if (last) begin
      cut_stage(k + 1, p, 1'b1);
      cut_started[k] = 1'b0;
    end
  endfunction

  function automatic void keep_point(xy_t p);
    if (pend_ok) cut_stage(0, pend_pt, 1'b0);
    pend_pt = p;
    pend_ok = 1'b1;
    kept_pt = p;
  endfunction

  function automatic bit beyond_radius(xy_t p);
    longint unsigned rq;
    longint unsigned thr;
    longint unsigned dx;
    longint unsigned dy;
    rq = longint'(radius) << FRAC_BITS;
    thr = rq * rq;
    dx = (p.x > kept_pt.x) ? p.x - kept_pt.x : kept_pt.x - p.x;
    dy = (p.y > kept_pt.y) ? p.y - kept_pt.y : kept_pt.y - p.y;
    return (dx * dx + dy * dy) > thr;
  endfunction

  function automatic void screen_point(xy_t p);
    if (radius == 0 || beyond_radius(p)) keep_point(p);
  endfunction

  function automatic void close_path();
    head_n = 0;
    pend_ok = 1'b0;
    for (int k = 0; k < MAX_PASSES; k++) cut_started[k] = 1'b0;
  endfunction

  // Works out every output point that one accepted input point causes.
  function automatic void predict_smoothing(path_item_t it);
    xy_t p;
    p.x = sext_coord(it.x);
    p.y = sext_coord(it.y);
    if (head_n < 3) begin
      head_pts[head_n] = p;
      head_n++;
      if (it.last) begin
        if (head_n <= 2) begin
          for (int i = 0; i < head_n; i++) emit_point(head_pts[i], i + 1 == head_n);
        end else begin
          cut_stage(0, head_pts[0], 1'b0);
          cut_stage(0, head_pts[1], 1'b0);
          cut_stage(0, head_pts[2], 1'b1);
        end
        close_path();
      end
      return;
    end
    if (!pend_ok) begin
      keep_point(head_pts[0]);
      screen_point(head_pts[1]);
      screen_point(head_pts[2]);
    end
    if (it.last) begin
      if (radius == 0 || p.x != kept_pt.x || p.y != kept_pt.y) keep_point(p);
      if (pend_ok) cut_stage(0, pend_pt, 1'b1);
      close_path();
    end else begin
      screen_point(p);
    end
  endfunction

  // Input driver: offers queued points with random gaps and predicts on acceptance.
  path_item_t cur_item;
  int         send_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (in_if.valid && in_if.ready) predict_smoothing(cur_item);
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (path_q.size() > 0) begin
        cur_item = path_q.pop_front();
        in_if.point_x    <= cur_item.x;
        in_if.point_y    <= cur_item.y;
        in_if.last_point <= cur_item.last;
        in_if.valid      <= 1'b1;
        send_gap = no_gaps ? 0 : $urandom_range(0, 5);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls per item, plus the long hold-off on request.
  int recv_wait;
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) recv_wait = no_gaps ? 0 : $urandom_range(0, 5);
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Output checker: each accepted point against the oldest predicted point.
  path_item_t want;
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      if (smoothed_q.size() == 0) begin
        $display("%0t: unexpected output point x=%0d y=%0d last=%0b", $time,
                 out_if.smooth_x, out_if.smooth_y, out_if.last_out);
        fails++;
      end else begin
        want = smoothed_q.pop_front();
        if (out_if.smooth_x !== want.x) begin
          $display("%0t: smooth_x expected %0d actual %0d", $time, want.x, out_if.smooth_x);
          fails++;
        end
        if (out_if.smooth_y !== want.y) begin
          $display("%0t: smooth_y expected %0d actual %0d", $time, want.y, out_if.smooth_y);
          fails++;
        end
        if (out_if.last_out !== want.last) begin
          $display("%0t: last_out expected %0b actual %0b", $time, want.last,
                   out_if.last_out);
          fails++;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
    @(posedge clk);
    cfg_if.index <= idx;
    cfg_if.data  <= value[RADIUS_BITS-1:0];
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_SMOOTH_PASSES) num_passes = value & 3;
    else radius = value & 12'hFFF;
  endtask

  // Waits until every queued point is taken and every result has come out.
  task automatic wait_quiet();
    wait (path_q.size() == 0 && !in_if.valid && smoothed_q.size() == 0);
    repeat (64) @(posedge clk);
  endtask

  task automatic add_point(longint x, longint y, bit last);
    path_item_t it;
    it.x = coord_t'(x);
    it.y = coord_t'(y);
    it.last = last;
    path_q.push_back(it);
  endtask

  // A random path: a walk with steps up to span, sometimes repeating a point,
  // sometimes starting from a full-range coordinate.
  task automatic add_path(int len, int span);
    longint x;
    longint y;
    if ($urandom_range(0, 3) == 0) begin
      x = sext_coord(coord_t'($urandom));
      y = sext_coord(coord_t'($urandom));
    end else begin
      x = $signed($urandom_range(0, 2097152)) - 1048576;
      y = $signed($urandom_range(0, 2097152)) - 1048576;
    end
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 4) != 0) begin
        x += $signed($urandom_range(0, 2 * span)) - span;
        y += $signed($urandom_range(0, 2 * span)) - span;
      end
      add_point(x, y, i == len - 1);
    end
  endtask

  int span;

  initial begin
    fails = 0;
    hold_off = 1'b0;
    no_gaps = 1'b0;
    num_passes = 2;
    radius = 35;
    head_n = 0;
    pend_ok = 1'b0;
    kept_pt = '{0, 0};
    pend_pt = '{0, 0};
    for (int k = 0; k < MAX_PASSES; k++) cut_started[k] = 1'b0;
    in_if.valid = 1'b0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.last_point = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SMOOTH_PASSES;
    cfg_if.data = '0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one-point, two-point and three-point paths at the extremes.
    add_point(8388607, -8388608, 1);
    add_point(-8388608, 8388607, 0);
    add_point(8388607, -8388608, 1);
    add_point(-8388608, -8388608, 0);
    add_point(8388607, 8388607, 0);
    add_point(-1, 0, 1);
    wait_quiet();

    // Deepest smoothing, simplification off.
    write_reg(REG_SMOOTH_PASSES, 3);
    write_reg(REG_DROP_RADIUS, 0);
    add_point(0, 0, 0);
    add_point(0, 0, 0);
    add_point(1000, -3, 0);
    add_point(-8388608, 8388607, 0);
    add_point(8388607, -8388608, 1);
    wait_quiet();

    // Largest radius: a path that collapses to its first point.
    write_reg(REG_DROP_RADIUS, 4095);
    add_point(256, 256, 0);
    add_point(300, 200, 0);
    add_point(-500, 100, 0);
    add_point(256, 256, 0);
    add_point(256, 256, 1);
    wait_quiet();

    // No smoothing, default radius, far and near points mixed.
    write_reg(REG_SMOOTH_PASSES, 0);
    write_reg(REG_DROP_RADIUS, 35);
    add_point(0, 0, 0);
    add_point(8960, 0, 0);
    add_point(8961, 0, 0);
    add_point(20000, 100, 0);
    add_point(20001, 100, 0);
    add_point(20001, 100, 1);
    wait_quiet();

    // Random phases across settings; one phase with no gaps, one with a hold-off.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_SMOOTH_PASSES, ph % 4);
      case (ph)
        1: write_reg(REG_DROP_RADIUS, 0);
        5: write_reg(REG_DROP_RADIUS, 4095);
        default: write_reg(REG_DROP_RADIUS, $urandom_range(1, 60));
      endcase
      no_gaps = (ph == 2);
      span = (radius == 0) ? 4000 : radius * 256 * 2;
      if (span > 65536 * 8) span = 65536 * 8;
      for (int n = 0; n < 8; n += 0) begin
        int len;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 9);
        add_path(len, span);
        n += len;
      end
      if (ph == 3) begin
        repeat (20) @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      wait_quiet();
    end
    no_gaps = 1'b0;

    wait_quiet();
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Run limit.
  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
